@@ design/pipc_pkg.sv @@
// shared types and constants for the pi position controller
package pipc_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ICOEFF = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd2;
    localparam int unsigned CFG_DATA_W = 24;

    // register widths and reset values
    localparam int unsigned KP_W     = 16;
    localparam int unsigned ICOEFF_W = 24;
    localparam int unsigned PERIOD_W = 17;
    localparam logic [KP_W-1:0]     KP_RESET     = 16'd12800;
    localparam logic [ICOEFF_W-1:0] ICOEFF_RESET = 24'd8389;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 17'd600;

    // datapath widths
    localparam int unsigned P_W      = 28;
    localparam int unsigned MUL_A_W  = 24;
    localparam int unsigned MUL_B_W  = 29;
    localparam int unsigned PROD_W   = MUL_A_W + 1 + MUL_B_W;
    localparam int unsigned OUT_Q_W  = 18;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned DUTY_W   = 10;
    localparam int unsigned CMP_W    = 16;
    localparam int unsigned FRAC_I   = 24;
    localparam int unsigned FRAC_CMP = 10;

    // output clamp, 1023.0 with 8 fraction bits
    localparam logic [OUT_Q_W-1:0] OUT_MAX_Q8 = 18'd261888;

    // controller sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_SAT_P,
        ST_MUL_I,
        ST_ACC,
        ST_MUL_C,
        ST_FIN
    } pipc_state_t;

    // sequencer controls to the datapath
    typedef struct packed {
        logic in_ready;
        logic mul_en;
        logic p_load;
        logic acc_load;
        logic out_load;
    } pipc_ctrl_t;

endpackage

@@ design/pipc_if.sv @@
// channel interfaces for the pi position controller

// input channel: samples and control ticks
interface pipc_in_if #(
    parameter int unsigned SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic                   op;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

// result channel: duty and pwm compare
interface pipc_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  duty;
    logic [15:0] compare;

    modport source (output valid, output duty, output compare, input ready);
    modport sink   (input valid, input duty, input compare, output ready);
endinterface

// configuration write channel
interface pipc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [23:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/pi_position_controller.sv @@
// pi position controller, tustin form with output clamp, on one shared multiplier
//
//  channel  | dir | payload               | transaction
//  ---------+-----+-----------------------+-------------------------------
//  in_ch    | in  | op, sample            | one sample or one control tick
//  out_ch   | out | duty, compare         | one result per control tick
//  cfg      | in  | index, data           | one register write
//
// a sample is stored on its transaction; a tick steps the sequencer through MUL_P,
// SAT_P, MUL_I, ACC, MUL_C and FIN (kp*err, coeff*sum, duty*period on the one
// 25 x 29 multiplier, each followed by a register); the result is loaded in FIN,
// which waits while the result slot is full, and the next item is taken in IDLE.
// in_ch is ready only in IDLE; cfg is always ready; a held result blocks input only
// by holding a tick in FIN. rst_n clears state and loads the defaults.
module pi_position_controller
    import pipc_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = 10
)(
    input  logic       clk,
    input  logic       rst_n,
    pipc_in_if.sink    in_ch,
    pipc_out_if.source out_ch,
    pipc_cfg_if.sink   cfg
);

    localparam int unsigned ERR_W = SAMPLE_BITS + 1;

    pipc_state_t state_reg, state_next;
    pipc_ctrl_t  ctrl;

    logic [KP_W-1:0]        kp_reg;
    logic [ICOEFF_W-1:0]    icoeff_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [SAMPLE_BITS-1:0] cmd_reg;
    logic [SAMPLE_BITS-1:0] meas_reg;
    logic                   chan_reg;
    logic signed [P_W-1:0]  p_reg;
    logic signed [P_W-1:0]  prev_p_reg;
    logic [OUT_Q_W-1:0]     prev_out_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                   out_valid_reg;
    logic [DUTY_W-1:0]      duty_reg;
    logic [CMP_W-1:0]       cmp_reg;

    logic signed [ERR_W-1:0]   err;
    logic [MUL_A_W-1:0]        mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [P_W-1:0]     p_sat;
    logic signed [PROD_W-FRAC_I-1:0] integ;
    logic signed [ACC_W-1:0]   acc;
    logic [OUT_Q_W-1:0]        out_clamp;
    logic [CMP_W-1:0]          cmp_sat;
    logic                      in_acc;

    assign in_acc   = in_ch.valid && ctrl.in_ready;

    // handshake outputs
    assign in_ch.ready    = ctrl.in_ready;
    assign cfg.ready      = 1'b1;
    assign out_ch.valid   = out_valid_reg;
    assign out_ch.duty    = duty_reg;
    assign out_ch.compare = cmp_reg;

    // sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and controls
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
                if (in_ch.valid && in_ch.op)
                begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_SAT_P;
            end
            ST_SAT_P:
            begin
                ctrl.p_load = 1'b1;
                state_next  = ST_MUL_I;
            end
            ST_MUL_I:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_ACC;
            end
            ST_ACC:
            begin
                ctrl.acc_load = 1'b1;
                state_next    = ST_MUL_C;
            end
            ST_MUL_C:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // position error
    assign err = $signed({1'b0, cmd_reg}) - $signed({1'b0, meas_reg});

    // shared multiplier operand selection
    always_comb
    begin
        case (state_reg)
            ST_MUL_I:
            begin
                mul_a = icoeff_reg;
                mul_b = MUL_B_W'(p_reg) + MUL_B_W'(prev_p_reg);
            end
            ST_MUL_C:
            begin
                mul_a = MUL_A_W'(period_reg);
                mul_b = $signed({{(MUL_B_W-DUTY_W){1'b0}}, prev_out_reg[OUT_Q_W-1 -: DUTY_W]});
            end
            default:
            begin
                mul_a = MUL_A_W'(kp_reg);
                mul_b = MUL_B_W'(err);
            end
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // saturate proportional term to the signed 28-bit range
    always_comb
    begin
        if (prod_reg[PROD_W-1:P_W-1] == '0 || prod_reg[PROD_W-1:P_W-1] == '1)
        begin
            p_sat = prod_reg[P_W-1:0];
        end
        else if (prod_reg[PROD_W-1])
        begin
            p_sat = {1'b1, {(P_W-1){1'b0}}};
        end
        else
        begin
            p_sat = {1'b0, {(P_W-1){1'b1}}};
        end
    end

    // integral term floored to 8 fraction bits, output update and clamp
    assign integ = prod_reg[PROD_W-1:FRAC_I];
    assign acc   = $signed({{(ACC_W-OUT_Q_W){1'b0}}, prev_out_reg})
                 + ACC_W'(p_reg) - ACC_W'(prev_p_reg) + ACC_W'(integ);

    always_comb
    begin
        if (acc[ACC_W-1])
        begin
            out_clamp = '0;
        end
        else if (acc > $signed({{(ACC_W-OUT_Q_W){1'b0}}, OUT_MAX_Q8}))
        begin
            out_clamp = OUT_MAX_Q8;
        end
        else
        begin
            out_clamp = acc[OUT_Q_W-1:0];
        end
    end

    // compare value, saturated to 16 bits
    assign cmp_sat = prod_reg[FRAC_CMP+CMP_W] ? '1 : prod_reg[FRAC_CMP+CMP_W-1:FRAC_CMP];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= KP_RESET;
            icoeff_reg <= ICOEFF_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_KP:     kp_reg     <= cfg.data[KP_W-1:0];
                CFG_ICOEFF: icoeff_reg <= cfg.data[ICOEFF_W-1:0];
                CFG_PERIOD: period_reg <= cfg.data[PERIOD_W-1:0];
                default:    ;
            endcase
        end
    end

    // position samples and controller history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg      <= '0;
            meas_reg     <= '0;
            chan_reg     <= 1'b0;
            prev_p_reg   <= '0;
            prev_out_reg <= '0;
        end
        else
        begin
            if (in_acc && !in_ch.op)
            begin
                if (!chan_reg)
                begin
                    cmd_reg <= in_ch.sample;
                end
                else
                begin
                    meas_reg <= in_ch.sample;
                end
                chan_reg <= !chan_reg;
            end
            if (ctrl.acc_load)
            begin
                prev_p_reg   <= p_reg;
                prev_out_reg <= out_clamp;
            end
        end
    end

    // multiplier product and proportional term
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (ctrl.p_load)
        begin
            p_reg <= p_sat;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            duty_reg <= prev_out_reg[OUT_Q_W-1 -: DUTY_W];
            cmp_reg  <= cmp_sat;
        end
    end

endmodule
